[src/dsdft_pkg.sv]
// Shared types, constants and helper functions of the damped sliding DFT.
// Holds the twiddle builder used at elaboration and the 32-bit saturator.
// No dependencies.
package dsdft_pkg;

    localparam int BIN_COUNT_DEF = 64;
    localparam int ROT_LAT       = 3;
    localparam int TW_W          = 19;
    localparam int BIAS_W        = 36;
    localparam int IR_W          = 35;
    localparam logic [16:0] DAMP_RST = 17'd65470;
    localparam logic [16:0] DPOW_RST = 17'd61446;
    localparam longint HALF_PI_Q30   = 64'sd1686629713;
    localparam longint ONE_Q30       = 64'sd1073741824;
    localparam longint Q56           = 64'sh0100_0000_0000_0000;

    // ceil(2^56 / d) for the series divisors (2i+1)(2i+2) and (2i+2)(2i+3)
    localparam longint TC_RCP [10] = '{
        (Q56 + 1) / 2,     (Q56 + 11) / 12,   (Q56 + 29) / 30,   (Q56 + 55) / 56,
        (Q56 + 89) / 90,   (Q56 + 131) / 132, (Q56 + 181) / 182, (Q56 + 239) / 240,
        (Q56 + 305) / 306, (Q56 + 379) / 380
    };
    localparam longint TS_RCP [10] = '{
        (Q56 + 5) / 6,     (Q56 + 19) / 20,   (Q56 + 41) / 42,   (Q56 + 71) / 72,
        (Q56 + 109) / 110, (Q56 + 155) / 156, (Q56 + 209) / 210, (Q56 + 271) / 272,
        (Q56 + 341) / 342, (Q56 + 419) / 420
    };

    typedef struct packed {
        logic signed [31:0] im;
        logic signed [31:0] re;
    } t_bin;

    // exact floor(x / d) for 0 <= x < 2^32 with m = ceil(2^56 / d)
    function automatic longint scale_rcp(input longint x, input longint m);
        logic [127:0] p;
        p = 128'(x) * 128'(m);
        return longint'(p >> 56);
    endfunction

    function automatic logic [2*TW_W-1:0] tw_entry(input longint quad, input longint a);
        longint a2;
        longint tc;
        longint ts;
        longint sc;
        longint ss;
        longint cq;
        longint sq;
        logic signed [TW_W-1:0] c;
        logic signed [TW_W-1:0] s;
        logic signed [TW_W-1:0] co;
        logic signed [TW_W-1:0] so;
        a2   = (a * a) >>> 30;
        tc   = ONE_Q30;
        ts   = a;
        sc   = 0;
        ss   = 0;
        for (int i = 0; i < 10; i++) begin
            sc = i[0] ? sc - tc : sc + tc;
            ss = i[0] ? ss - ts : ss + ts;
            tc = scale_rcp((tc * a2) >>> 30, TC_RCP[i]);
            ts = scale_rcp((ts * a2) >>> 30, TS_RCP[i]);
        end
        if (sc < 0) sc = 0;
        if (sc > ONE_Q30) sc = ONE_Q30;
        if (ss < 0) ss = 0;
        if (ss > ONE_Q30) ss = ONE_Q30;
        cq = (sc + 4096) >>> 13;
        sq = (ss + 4096) >>> 13;
        c  = TW_W'(cq);
        s  = TW_W'(sq);
        case (quad[1:0])
            2'd0: begin co = c;  so = s;  end
            2'd1: begin co = -s; so = c;  end
            2'd2: begin co = -c; so = -s; end
            default: begin co = s; so = -c; end
        endcase
        return {co, so};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -40'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

[src/damped_sliding_dft_hann.sv]
// Top level of the damped sliding DFT with circular Hann window.
// Depends on dsdft_pkg, dsdft_cell and dsdft_rot.
//
// Usage: each sample beat on the s-side stream (tdata[15:0], Q1.15) shifts a
// line of BIN_COUNT sample cells and updates every bin. Bins live in a ring of
// cells that rotates one place per cycle through a three-stage update unit.
// A setup state follows, then the ring rotates once more to emit BIN_COUNT
// windowed bins on the m-side stream, one beat per cycle while the receiver
// is ready, tlast on the last bin, tuser set once a full window of samples
// has been seen. A stall of the receiver holds the ring and the output
// register; tready on the s side is high only between items. Reset clears all
// bins, the sample line, the fill count and restores the damping registers,
// which are written over the APB port at offsets 0 and 4.
module damped_sliding_dft_hann #(
    parameter int BIN_COUNT = dsdft_pkg::BIN_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] sample
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [5:0] bin_index, [37:6] bin_real, [69:38] bin_imag
    output logic        o_m_tlast,
    output logic        o_m_tuser,   // [0] spectrum_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int L  = dsdft_pkg::ROT_LAT;
    localparam int KW = $clog2(BIN_COUNT);
    localparam int CW = $clog2(BIN_COUNT + L);
    localparam int BW = $bits(dsdft_pkg::t_bin);
    localparam logic [CW-1:0] UPD_LAST = CW'(BIN_COUNT + L - 1);
    localparam logic [CW-1:0] WIN_LAST = CW'(BIN_COUNT - 1);
    localparam logic [CW-1:0] N_C      = CW'(BIN_COUNT);
    localparam logic [KW-1:0] FILL_LAST = KW'(BIN_COUNT - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_WSET = 2'd2;
    localparam logic [1:0] S_WIN  = 2'd3;

    localparam logic ADDR_DAMP = 1'b0;
    localparam logic ADDR_DPOW = 1'b1;

    logic [1:0]  r_st;
    logic [1:0]  n_st;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [16:0] r_damp;
    logic [16:0] r_dpow;
    logic [KW-1:0] r_fill;
    logic        r_filled;
    logic signed [dsdft_pkg::BIAS_W-1:0] r_bias;
    dsdft_pkg::t_bin r_prev;
    dsdft_pkg::t_bin r_first;

    logic        r_ov;
    logic [5:0]  r_oidx;
    logic [31:0] r_ore;
    logic [31:0] r_oim;
    logic        r_olast;
    logic        r_ouser;

    logic        s_acc;
    logic        cfg_wr;
    logic        slot;
    logic        win_ld;
    logic        ring_en;
    logic [15:0] smp [BIN_COUNT];
    dsdft_pkg::t_bin ring [BIN_COUNT];
    dsdft_pkg::t_bin tail_d;
    dsdft_pkg::t_bin rot_out;
    dsdft_pkg::t_bin hi;
    logic [KW-1:0] rot_k;
    logic signed [34:0] wr;
    logic signed [34:0] wi;
    logic signed [17:0] dpow_s;

    assign s_acc  = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_st == S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign slot   = !r_ov || i_m_tready;
    assign win_ld = (r_st == S_WIN) && slot;
    assign ring_en = (r_st == S_UPD) || win_ld;
    assign tail_d = (r_st == S_UPD) ? rot_out : ring[0];
    assign rot_k  = (r_cnt < N_C) ? r_cnt[KW-1:0] : '0;
    assign dpow_s = $signed({1'b0, r_dpow});

    for (genvar g = 0; g < BIN_COUNT; g++) begin : g_cells
        dsdft_cell #(.W(16)) u_smp (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_acc),
            .i_d     ((g == 0) ? i_s_tdata : smp[(g == 0) ? 0 : g - 1]),
            .o_q     (smp[g])
        );
        dsdft_cell #(.W(BW)) u_bin (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (ring_en),
            .i_d     ((g == BIN_COUNT - 1) ? tail_d
                                           : ring[(g == BIN_COUNT - 1) ? g : g + 1]),
            .o_q     (ring[g])
        );
    end

    dsdft_rot #(.BIN_COUNT(BIN_COUNT)) u_rot (
        .i_clk  (i_clk),
        .i_bin  (ring[0]),
        .i_k    (rot_k),
        .i_damp (r_damp),
        .i_bias (r_bias),
        .o_bin  (rot_out)
    );

    assign hi = (r_cnt == WIN_LAST) ? r_first : ring[(BIN_COUNT > 1) ? 1 : 0];
    assign wr = (35'(ring[0].re) <<< 1) - 35'(r_prev.re) - 35'(hi.re) + 35'sd2;
    assign wi = (35'(ring[0].im) <<< 1) - 35'(r_prev.im) - 35'(hi.im) + 35'sd2;

    always_comb begin
        n_st  = r_st;
        n_cnt = r_cnt;
        unique case (r_st)
            S_IDLE: begin
                if (s_acc) begin
                    n_st  = S_UPD;
                    n_cnt = '0;
                end
            end
            S_UPD: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == UPD_LAST) begin
                    n_st  = S_WSET;
                    n_cnt = '0;
                end
            end
            S_WSET: begin
                n_st = S_WIN;
            end
            S_WIN: begin
                if (slot) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == WIN_LAST) begin
                        n_st = S_IDLE;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_cnt    <= '0;
            r_damp   <= dsdft_pkg::DAMP_RST;
            r_dpow   <= dsdft_pkg::DPOW_RST;
            r_fill   <= '0;
            r_filled <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
            if (cfg_wr) begin
                unique case (paddr[2])
                    ADDR_DAMP: r_damp <= pwdata[16:0];
                    ADDR_DPOW: r_dpow <= pwdata[16:0];
                    default: ;
                endcase
            end
            if (s_acc && !r_filled) begin
                if (r_fill == FILL_LAST) begin
                    r_filled <= 1'b1;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (win_ld) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_bias <= dsdft_pkg::BIAS_W'($signed({i_s_tdata, 16'h0000}))
                    - dsdft_pkg::BIAS_W'(dpow_s * $signed(smp[BIN_COUNT - 1]))
                    + dsdft_pkg::BIAS_W'(32768);
        end
        if (r_st == S_WSET) begin
            r_prev  <= ring[BIN_COUNT - 1];
            r_first <= ring[0];
        end else if (win_ld) begin
            r_prev <= ring[0];
        end
        if (win_ld) begin
            r_oidx  <= 6'(r_cnt);
            r_ore   <= dsdft_pkg::sat32(40'(wr >>> 2));
            r_oim   <= dsdft_pkg::sat32(40'(wi >>> 2));
            r_olast <= (r_cnt == WIN_LAST);
            r_ouser <= r_filled;
        end
    end

    always_comb begin
        unique case (paddr[2])
            ADDR_DAMP: prdata = {15'd0, r_damp};
            ADDR_DPOW: prdata = {15'd0, r_dpow};
            default:   prdata = '0;
        endcase
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {2'b00, r_oim, r_ore, r_oidx};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ouser;
endmodule

[src/dsdft_cell.sv]
// One storage cell of a shifting chain: loads its neighbor's value when enabled.
// Depends on nothing; used for the bin ring and the sample line.
module dsdft_cell #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule

[src/dsdft_rot.sv]
// Three-stage bin update: damp and add input, then rotate by the twiddle.
// Depends on dsdft_pkg (bin type, twiddle builder, saturator).
module dsdft_rot #(
    parameter int BIN_COUNT = dsdft_pkg::BIN_COUNT_DEF
) (
    input  logic                                   i_clk,
    input  dsdft_pkg::t_bin                        i_bin,
    input  logic [$clog2(BIN_COUNT)-1:0]           i_k,
    input  logic [16:0]                            i_damp,
    input  logic signed [dsdft_pkg::BIAS_W-1:0]    i_bias,
    output dsdft_pkg::t_bin                        o_bin
);
    localparam int KW = $clog2(BIN_COUNT);
    localparam int TW = dsdft_pkg::TW_W;
    localparam int IW = dsdft_pkg::IR_W;

    logic [2*TW-1:0] tw_rom [BIN_COUNT];

    for (genvar g = 0; g < BIN_COUNT; g++) begin : g_tw
        localparam longint QUAD = (4 * longint'(g)) / BIN_COUNT;
        localparam longint REM  = (4 * longint'(g)) % BIN_COUNT;
        localparam longint ANG  = REM * dsdft_pkg::HALF_PI_Q30 / BIN_COUNT;
        localparam logic [2*TW-1:0] TWG = dsdft_pkg::tw_entry(QUAD, ANG);
        assign tw_rom[g] = TWG;
    end

    logic signed [49:0]      r_pr;
    logic signed [49:0]      r_pi;
    logic [KW-1:0]           r_k;
    logic signed [IW-1:0]    r_ir;
    logic signed [IW-1:0]    r_ii;
    logic signed [TW-1:0]    r_c;
    logic signed [TW-1:0]    r_s;
    logic signed [53:0]      r_m1;
    logic signed [53:0]      r_m2;
    logic signed [53:0]      r_m3;
    logic signed [53:0]      r_m4;
    logic signed [50:0]      sum_r;
    logic signed [50:0]      sum_i;
    logic signed [54:0]      rot_r;
    logic signed [54:0]      rot_i;
    logic signed [17:0]      damp_s;

    assign damp_s = $signed({1'b0, i_damp});
    assign sum_r  = 51'(r_pr) + 51'(i_bias);
    assign sum_i  = 51'(r_pi) + 51'sd32768;

    always_ff @(posedge i_clk) begin
        r_pr <= damp_s * i_bin.re;
        r_pi <= damp_s * i_bin.im;
        r_k  <= i_k;
        r_ir <= IW'(sum_r >>> 16);
        r_ii <= IW'(sum_i >>> 16);
        r_c  <= tw_rom[r_k][2*TW-1:TW];
        r_s  <= tw_rom[r_k][TW-1:0];
        r_m1 <= r_ir * r_c;
        r_m2 <= r_ii * r_s;
        r_m3 <= r_ir * r_s;
        r_m4 <= r_ii * r_c;
    end

    assign rot_r = 55'(r_m1) - 55'(r_m2) + 55'sd65536;
    assign rot_i = 55'(r_m3) + 55'(r_m4) + 55'sd65536;

    assign o_bin.re = dsdft_pkg::sat32(40'(rot_r >>> 17));
    assign o_bin.im = dsdft_pkg::sat32(40'(rot_i >>> 17));
endmodule

[src/dsdft_chk.sv]
// Port-level checks of the damped sliding DFT, bound to the top level.
// Depends on the top level's port list only.
module dsdft_chk #(
    parameter int BIN_COUNT = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output beat dropped while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("sample taken while a pass runs");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[5:0] == 6'(BIN_COUNT - 1))
        else $error("tlast on wrong bin");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser |=> !o_m_tvalid || o_m_tuser)
        else $error("spectrum valid fell");
endmodule

bind damped_sliding_dft_hann dsdft_chk #(.BIN_COUNT(BIN_COUNT)) u_dsdft_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
